/* src/lphs_pkg.sv */
// package for the linear probing hash set: codes, states, command/status structs
// no dependencies
package lphs_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int BC_W = 11;
    localparam logic [31:0] HASH_MUL = 32'h82F63B78;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_PRESENT = 3'd2,
        ST_FULL = 3'd3, ST_BAD = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MD_FIND = 2'd0, MD_INSERT = 2'd1, MD_ERASE = 2'd2, MD_NONE = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_PRB_RD, S_PRB_CHK,
        S_ER_RD, S_ER_CHK, S_RE_RD, S_RE_CHK, S_RE_HASH1, S_RE_HASH2,
        S_RE_PRD, S_RE_PCHK, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // capture input item
        logic clr_start;    // restart clear sweep
        logic clr_step;     // write zero at clear index
        logic hash1;        // first hash stage from probe key
        logic hash2;        // second hash stage, sets probe index
        logic rd_probe;     // read at probe index
        logic step_probe;   // advance probe index
        logic rd_pos;       // read at erase index
        logic step_pos;     // advance erase index
        logic wr_key;       // write input key at probe index, count up
        logic wr_zero_pos;  // write zero at erase index
        logic wr_pkey_prb;  // write probe key at probe index
        logic cnt_dec;      // count down
        logic pkey_from_rd; // probe key takes memory read data
        logic pkey_from_in; // probe key takes input key
        logic init_scan;    // scan counter to zero
        logic set_res;      // latch result
        t_status res_st;
        logic res_bkt_prb;  // result bucket from probe index
        logic res_bkt_pos;  // result bucket from position
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic key_zero;
        logic pos_bad;
        logic rd_zero;
        logic rd_hit;
        logic scan_end;
        logic full;
        t_mode mode;
    } t_sts;

endpackage

/* src/lphs_ram.sv */
// generic single port ram with registered read
// no dependencies
module lphs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* src/lphs_datapath.sv */
// datapath: item registers, hash, probe and erase indexes, key memory, count
// depends on lphs_pkg, lphs_ram
module lphs_datapath #(
    parameter int MAX_BUCKETS = lphs_pkg::MAX_BUCKETS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lphs_pkg::t_cmd     i_cmd,
    output lphs_pkg::t_sts     o_sts,
    input  logic [1:0]         i_mode,
    input  logic [63:0]        i_key,
    input  logic [9:0]         i_position,
    input  logic [lphs_pkg::BC_W-1:0] i_bc,
    output logic [2:0]         o_res_status,
    output logic [9:0]         o_res_bucket,
    output logic [9:0]         o_res_count
);
    localparam int AW = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = $clog2(MAX_BUCKETS + 1);

    logic [1:0]  r_mode;
    logic [63:0] r_key, r_pkey;
    logic [9:0]  r_pos;
    logic [AW-1:0] r_pidx, r_eidx, r_clr;
    logic [CW-1:0] r_cnt, r_scan;
    logic [30:0] r_seed;
    logic [9:0]  r_bkt;
    logic [2:0]  r_st;
    logic [AW+31:0] w_prod;
    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [63:0] w_wdata, w_rdata;
    logic [CW-1:0] w_bc;
    logic [AW-1:0] w_pnext, w_enext;

    assign w_bc = CW'(i_bc);
    assign w_prod = (AW+32)'(w_bc) * (AW+32)'(r_seed);
    assign w_pnext = ({1'b0, r_pidx} + 1'b1 >= (AW+1)'(w_bc)) ? '0 : r_pidx + 1'b1;
    assign w_enext = ({1'b0, r_eidx} + 1'b1 >= (AW+1)'(w_bc)) ? '0 : r_eidx + 1'b1;

    // memory port select
    always_comb begin
        w_we = 1'b0;
        w_addr = r_pidx;
        w_wdata = '0;
        if (i_cmd.clr_step) begin
            w_we = 1'b1; w_addr = r_clr;
        end else if (i_cmd.wr_key) begin
            w_we = 1'b1; w_wdata = r_key;
        end else if (i_cmd.wr_pkey_prb) begin
            w_we = 1'b1; w_wdata = r_pkey;
        end else if (i_cmd.wr_zero_pos) begin
            w_we = 1'b1; w_addr = r_eidx;
        end else if (i_cmd.rd_pos) begin
            w_addr = r_eidx;
        end
    end

    lphs_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.wr_key) r_cnt <= r_cnt + 1'b1;
            else if (i_cmd.cnt_dec) r_cnt <= r_cnt - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode; r_key <= i_key; r_pos <= i_position;
            r_eidx <= AW'(i_position);
        end else if (i_cmd.step_pos) begin
            r_eidx <= w_enext;
        end
        if (i_cmd.pkey_from_in) r_pkey <= i_key;
        else if (i_cmd.pkey_from_rd) r_pkey <= w_rdata;
        if (i_cmd.hash1) r_seed <= 31'((r_pkey[31:0] * lphs_pkg::HASH_MUL) >> 1);
        if (i_cmd.hash2) r_pidx <= AW'(w_prod >> 31);
        else if (i_cmd.step_probe) r_pidx <= w_pnext;
        // scan counter: probed buckets on find and insert, followers on erase
        if (i_cmd.init_scan) r_scan <= '0;
        else if (i_cmd.step_pos ||
                 (i_cmd.step_probe && lphs_pkg::t_mode'(r_mode) != lphs_pkg::MD_ERASE))
            r_scan <= r_scan + 1'b1;
        if (i_cmd.set_res) begin
            r_st <= i_cmd.res_st;
            r_bkt <= i_cmd.res_bkt_prb ? 10'(r_pidx) :
                     (i_cmd.res_bkt_pos ? r_pos : 10'd0);
        end
    end

    assign o_sts.clr_done = (r_clr == AW'(MAX_BUCKETS - 1));
    assign o_sts.key_zero = (r_key == 64'd0);
    assign o_sts.pos_bad  = ({1'b0, r_pos} >= 11'(i_bc));
    assign o_sts.rd_zero  = (w_rdata == 64'd0);
    assign o_sts.rd_hit   = (w_rdata == r_pkey);
    assign o_sts.scan_end = (r_scan + 1'b1 >= w_bc);
    assign o_sts.full     = (r_cnt >= (w_bc >> 1));
    assign o_sts.mode     = lphs_pkg::t_mode'(r_mode);
    assign o_res_status   = r_st;
    assign o_res_bucket   = r_bkt;
    assign o_res_count    = 10'(r_cnt);
endmodule

/* src/lphs_ctrl.sv */
// controller state machine for find, insert, erase with reinsertion, clear
// depends on lphs_pkg
module lphs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_in_fire,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  lphs_pkg::t_sts i_sts,
    output lphs_pkg::t_cmd o_cmd
);
    lphs_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) r_state <= lphs_pkg::S_CLEAR;
        else r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.res_st = lphs_pkg::ST_BAD;
        o_cmd.clr_start = i_cfg_we;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            lphs_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = lphs_pkg::S_IDLE;
            end
            lphs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_in = i_in_fire;
                o_cmd.pkey_from_in = i_in_fire;
                if (i_in_fire) n_state = lphs_pkg::S_HASH1;
            end
            lphs_pkg::S_HASH1: begin
                o_cmd.set_res = 1'b1;
                o_cmd.init_scan = 1'b1;
                if (i_sts.mode == lphs_pkg::MD_ERASE) begin
                    if (i_sts.pos_bad) n_state = lphs_pkg::S_OUT;
                    else begin
                        o_cmd.rd_pos = 1'b1;
                        n_state = lphs_pkg::S_ER_RD;
                    end
                end else if (i_sts.mode == lphs_pkg::MD_NONE || i_sts.key_zero) begin
                    n_state = lphs_pkg::S_OUT;
                end else begin
                    o_cmd.hash1 = 1'b1;
                    n_state = lphs_pkg::S_HASH2;
                end
            end
            lphs_pkg::S_HASH2: begin
                o_cmd.hash2 = 1'b1;
                n_state = lphs_pkg::S_PRB_RD;
            end
            lphs_pkg::S_PRB_RD: begin
                o_cmd.rd_probe = 1'b1;
                n_state = lphs_pkg::S_PRB_CHK;
            end
            lphs_pkg::S_PRB_CHK: begin
                o_cmd.set_res = 1'b1;
                if (i_sts.rd_zero) begin
                    n_state = lphs_pkg::S_OUT;
                    if (i_sts.mode == lphs_pkg::MD_FIND) begin
                        o_cmd.res_st = lphs_pkg::ST_NOT_FOUND;
                    end else if (i_sts.full) begin
                        o_cmd.res_st = lphs_pkg::ST_FULL;
                    end else begin
                        o_cmd.res_st = lphs_pkg::ST_OK;
                        o_cmd.res_bkt_prb = 1'b1;
                        o_cmd.wr_key = 1'b1;
                    end
                end else if (i_sts.rd_hit) begin
                    n_state = lphs_pkg::S_OUT;
                    o_cmd.res_bkt_prb = 1'b1;
                    o_cmd.res_st = (i_sts.mode == lphs_pkg::MD_FIND) ?
                                   lphs_pkg::ST_OK : lphs_pkg::ST_PRESENT;
                end else if (i_sts.scan_end) begin
                    n_state = lphs_pkg::S_OUT;
                    o_cmd.res_st = (i_sts.mode == lphs_pkg::MD_FIND) ?
                                   lphs_pkg::ST_NOT_FOUND : lphs_pkg::ST_FULL;
                end else begin
                    o_cmd.set_res = 1'b0;
                    o_cmd.step_probe = 1'b1;
                    n_state = lphs_pkg::S_PRB_RD;
                end
            end
            lphs_pkg::S_ER_RD: begin
                o_cmd.rd_pos = 1'b1;
                n_state = lphs_pkg::S_ER_CHK;
            end
            lphs_pkg::S_ER_CHK: begin
                o_cmd.set_res = 1'b1;
                if (i_sts.rd_zero) begin
                    o_cmd.res_st = lphs_pkg::ST_NOT_FOUND;
                    n_state = lphs_pkg::S_OUT;
                end else begin
                    o_cmd.res_st = lphs_pkg::ST_OK;
                    o_cmd.res_bkt_pos = 1'b1;
                    o_cmd.wr_zero_pos = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state = lphs_pkg::S_RE_RD;
                end
            end
            // follower walk: n counts scanned buckets via the probe scan counter
            lphs_pkg::S_RE_RD: begin
                if (i_sts.scan_end) n_state = lphs_pkg::S_OUT;
                else begin
                    o_cmd.step_pos = 1'b1;
                    n_state = lphs_pkg::S_RE_CHK;
                end
            end
            lphs_pkg::S_RE_CHK: begin
                o_cmd.rd_pos = 1'b1;
                n_state = lphs_pkg::S_RE_HASH1;
            end
            lphs_pkg::S_RE_HASH1: begin
                if (i_sts.rd_zero) n_state = lphs_pkg::S_OUT;
                else begin
                    o_cmd.pkey_from_rd = 1'b1;
                    o_cmd.wr_zero_pos = 1'b1;
                    n_state = lphs_pkg::S_RE_HASH2;
                end
            end
            lphs_pkg::S_RE_HASH2: begin
                o_cmd.hash1 = 1'b1;
                n_state = lphs_pkg::S_RE_PRD;
            end
            lphs_pkg::S_RE_PRD: begin
                o_cmd.hash2 = 1'b1;
                n_state = lphs_pkg::S_RE_PCHK;
            end
            lphs_pkg::S_RE_PCHK: begin
                o_cmd.rd_probe = 1'b1;
                n_state = lphs_pkg::S_PRB_RD;
            end
            lphs_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = lphs_pkg::S_IDLE;
            end
            default: n_state = lphs_pkg::S_IDLE;
        endcase
        // reinsert probing reuses the probe states with erase mode
        if ((r_state == lphs_pkg::S_PRB_CHK) && (i_sts.mode == lphs_pkg::MD_ERASE)) begin
            o_cmd.set_res = 1'b0;
            o_cmd.wr_key = 1'b0;
            o_cmd.step_probe = 1'b0;
            if (i_sts.rd_zero) begin
                o_cmd.wr_pkey_prb = 1'b1;
                n_state = lphs_pkg::S_RE_RD;
            end else begin
                o_cmd.step_probe = 1'b1;
                n_state = lphs_pkg::S_PRB_RD;
            end
        end
        if ((r_state == lphs_pkg::S_RE_PCHK) || (r_state == lphs_pkg::S_ER_CHK)) begin
            o_cmd.init_scan = (r_state == lphs_pkg::S_ER_CHK);
        end
    end
endmodule

/* src/linear_probe_hash_set.sv */
// Hash set with linear probing: find, insert, erase with follower reinsertion.
// Find and insert hash the key, then probe bucket by bucket; a successful erase empties the
// bucket, then takes up each follower and reinserts it by probing; erase of an empty bucket,
// zero key, bad mode or bad position end without probing. One item at a time through the
// single key memory port; the next item is accepted only once the result has been taken.
// Reset and a bucket_count write start a clearing pass over MAX_BUCKETS buckets, no input.
module linear_probe_hash_set #(
    parameter int MAX_BUCKETS = lphs_pkg::MAX_BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // mode[1:0], key[65:2], position[75:66]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status[2:0], bucket[12:3], entry_count[22:13]
);
    logic [10:0] r_bc;
    lphs_pkg::t_cmd w_cmd;
    lphs_pkg::t_sts w_sts;
    logic [2:0] w_st;
    logic [9:0] w_bkt, w_cnt;

    // bucket count register with clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bc <= 11'd127;
        else if (i_cfg_we) begin
            if (i_cfg_wdata < 11'd2) r_bc <= 11'd2;
            else if (32'(i_cfg_wdata) > MAX_BUCKETS) r_bc <= 11'(MAX_BUCKETS);
            else r_bc <= i_cfg_wdata;
        end
    end

    lphs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_in_fire(s_axis_tvalid & s_axis_tready), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lphs_datapath #(.MAX_BUCKETS(MAX_BUCKETS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode(s_axis_tdata[1:0]), .i_key(s_axis_tdata[65:2]),
        .i_position(s_axis_tdata[75:66]), .i_bc(r_bc),
        .o_res_status(w_st), .o_res_bucket(w_bkt), .o_res_count(w_cnt)
    );

    assign m_axis_tdata = {1'b0, w_cnt, w_bkt, w_st};
endmodule

/* tb/tb.sv */
// testbench for linear_probe_hash_set: directed and random find/insert/erase items
// depends on src/lphs_pkg.sv and src/linear_probe_hash_set.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // mode[1:0], key[65:2], position[75:66]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // status[2:0], bucket[12:3], entry_count[22:13]

    linear_probe_hash_set u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the set
    logic [63:0] shadow_keys [0:1023];
    int unsigned shadow_count;
    int unsigned shadow_buckets;

    typedef struct packed {
        lphs_pkg::t_status status;
        logic [9:0]        bucket;
        logic [9:0]        entries;
    } t_answer;

    t_answer     answer_q[$];
    int          error_count = 0;
    bit          no_idle = 1'b0;
    logic [63:0] key_pool[$];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < 1024; i++) shadow_keys[i] = '0;
        shadow_count = 0;
    endfunction

    function automatic int unsigned start_of(input logic [63:0] k);
        logic [31:0] seed;
        logic [63:0] prod;
        seed = k[31:0] * lphs_pkg::HASH_MUL;
        prod = 64'(shadow_buckets) * 64'(seed >> 1);
        return int'(prod >> 31);
    endfunction

    // walk to the key or the first empty bucket; shadow_buckets if none
    function automatic int unsigned slot_of(input logic [63:0] k, output bit hit);
        int unsigned i;
        i = start_of(k);
        hit = 1'b0;
        for (int n = 0; n < shadow_buckets; n++) begin
            if (shadow_keys[i] == 0) return i;
            if (shadow_keys[i] == k) begin
                hit = 1'b1;
                return i;
            end
            i = (i + 1 >= shadow_buckets) ? 0 : i + 1;
        end
        return shadow_buckets;
    endfunction

    function automatic t_answer apply_item(input lphs_pkg::t_mode md, input logic [63:0] k,
                                           input logic [9:0] pos);
        t_answer a;
        bit hit;
        int unsigned b, i;
        logic [63:0] moved;
        a.status = lphs_pkg::ST_BAD;
        a.bucket = '0;
        if (md == lphs_pkg::MD_FIND && k != 0) begin
            b = slot_of(k, hit);
            a.status = hit ? lphs_pkg::ST_OK : lphs_pkg::ST_NOT_FOUND;
            if (hit) a.bucket = b[9:0];
        end else if (md == lphs_pkg::MD_INSERT && k != 0) begin
            b = slot_of(k, hit);
            if (hit) begin
                a.status = lphs_pkg::ST_PRESENT;
                a.bucket = b[9:0];
            end else if (shadow_count >= shadow_buckets / 2 || b >= shadow_buckets) begin
                a.status = lphs_pkg::ST_FULL;
            end else begin
                shadow_keys[b] = k;
                shadow_count++;
                a.status = lphs_pkg::ST_OK;
                a.bucket = b[9:0];
            end
        end else if (md == lphs_pkg::MD_ERASE && pos < shadow_buckets) begin
            if (shadow_keys[pos] == 0) begin
                a.status = lphs_pkg::ST_NOT_FOUND;
            end else begin
                // empty the bucket, then reinsert the run behind it
                shadow_keys[pos] = '0;
                shadow_count--;
                i = pos;
                for (int n = 1; n < shadow_buckets; n++) begin
                    i = (i + 1 >= shadow_buckets) ? 0 : i + 1;
                    moved = shadow_keys[i];
                    if (moved == 0) break;
                    shadow_keys[i] = '0;
                    b = slot_of(moved, hit);
                    if (b < shadow_buckets) shadow_keys[b] = moved;
                end
                a.status = lphs_pkg::ST_OK;
                a.bucket = pos;
            end
        end
        a.entries = shadow_count[9:0];
        return a;
    endfunction

    // send one item with a random gap in front
    task automatic send_item(input lphs_pkg::t_mode md, input logic [63:0] k,
                             input logic [9:0] pos);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 12) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pos, k, md};
        do @(posedge i_clk); while (!s_axis_tready);
        answer_q.push_back(apply_item(md, k, pos));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [10:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_buckets = (v < 2) ? 2 : (v > 1024) ? 1024 : v;
        clear_shadow();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {lphs_pkg::t_status'(m_axis_tdata[2:0]), m_axis_tdata[12:3],
                   m_axis_tdata[22:13]};
            if (answer_q.size() == 0) begin
                report($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = answer_q.pop_front();
                if (got.status != want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.bucket != want.bucket)
                    report($sformatf("bucket %0d want %0d", got.bucket, want.bucket));
                if (got.entries != want.entries)
                    report($sformatf("entry_count %0d want %0d", got.entries, want.entries));
            end
        end
        m_axis_tready <= no_idle || ($urandom_range(99) >= 12);
    end

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [9:0] slot_after(input logic [63:0] k);
        bit hit;
        return 10'(slot_of(k, hit));
    endfunction

    // special cases at the reset bucket count
    task automatic test_reset_specials();
        logic [63:0] k;
        k = rand_key() | 64'h1;
        send_item(lphs_pkg::MD_FIND, k, '0);
        send_item(lphs_pkg::MD_FIND, 64'h0, '0);
        send_item(lphs_pkg::MD_INSERT, 64'h0, '0);
        send_item(lphs_pkg::MD_INSERT, k, '0);
        send_item(lphs_pkg::MD_INSERT, k, '0);
        send_item(lphs_pkg::MD_FIND, k, '0);
        send_item(lphs_pkg::MD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_item(lphs_pkg::MD_INSERT, {32'h0, k[31:0]} ^ 64'h8000_0000_0000_0000, '0);
        send_item(lphs_pkg::MD_NONE, k, 10'h3FF);
        send_item(lphs_pkg::MD_ERASE, '0, 10'd127);
        send_item(lphs_pkg::MD_ERASE, '0, 10'h3FF);
        send_item(lphs_pkg::MD_ERASE, '0, slot_after(k));
        send_item(lphs_pkg::MD_ERASE, '0, 10'd126);
        send_item(lphs_pkg::MD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    endtask

    // tiny tables: clamp of low writes, fill limit, erase with followers
    task automatic test_small_tables();
        write_buckets(11'd0);
        send_item(lphs_pkg::MD_INSERT, 64'h5, '0);
        send_item(lphs_pkg::MD_INSERT, 64'h7, '0);
        send_item(lphs_pkg::MD_ERASE, '0, 10'd2);
        send_item(lphs_pkg::MD_ERASE, '0, 10'd0);
        send_item(lphs_pkg::MD_ERASE, '0, 10'd1);
        send_item(lphs_pkg::MD_FIND, 64'h5, '0);
        write_buckets(11'd8);
        for (int i = 1; i <= 6; i++) send_item(lphs_pkg::MD_INSERT, 64'(i * 8), '0);
        for (int p = 0; p < 8; p++) send_item(lphs_pkg::MD_ERASE, '0, 10'(p));
    endtask

    // mixed traffic over a pool of keys, some sharing their low half
    task automatic random_phase(input logic [10:0] buckets, input int items);
        int r;
        logic [63:0] k;
        logic [9:0] pos;
        lphs_pkg::t_mode md;
        write_buckets(buckets);
        key_pool.delete();
        for (int i = 0; i < shadow_buckets / 2 + 6; i++) begin
            k = rand_key();
            if (i > 0 && $urandom_range(3) == 0) k[31:0] = key_pool[$urandom_range(i - 1)][31:0];
            key_pool.push_back(k == 0 ? 64'h1 : k);
        end
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            pos = 10'($urandom_range(shadow_buckets - 1));
            if (r < 45) md = lphs_pkg::MD_INSERT;
            else if (r < 72) md = lphs_pkg::MD_FIND;
            else if (r < 94) md = lphs_pkg::MD_ERASE;
            else if (r < 96) md = lphs_pkg::MD_NONE;
            else begin
                md = lphs_pkg::t_mode'($urandom_range(1));
                k = (r < 98) ? 64'h0 : rand_key();
            end
            if (md == lphs_pkg::MD_ERASE && $urandom_range(9) == 0) pos = 10'($urandom);
            send_item(md, k, pos);
            if (n == items / 2) drain();
        end
    endtask

    initial begin
        shadow_buckets = 127;
        clear_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_specials();
        test_small_tables();
        random_phase(11'd4, 100);
        random_phase(11'd16, 300);
        no_idle = 1'b1;
        random_phase(11'd64, 250);
        no_idle = 1'b0;
        random_phase(11'd127, 270);
        random_phase(11'd33, 300);
        random_phase(11'd2047, 260);
        random_phase(11'd1024, 60);
        random_phase(11'd3, 60);
        drain();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #80ms;
        $display("FAIL");
        $finish;
    end
endmodule
